FILE: hdl/gdh_pkg.sv
// shared types, constants and width helpers for the grid distance heuristic
`default_nettype none

package gdh_pkg;

  // fixed field widths of the transactions and registers
  localparam int COORD_W    = 10;
  localparam int METRIC_W   = 3;
  localparam int COST_W     = 16;
  localparam int EST_W      = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  // register indexes (byte address is four times the index)
  localparam logic [REG_IDX_W-1:0] REG_GOAL_ROW      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GOAL_COL      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_METRIC_KIND   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STRAIGHT_COST = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DIAG_COST     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT        = 3'd5;

  // reset values, costs in unsigned Q8.8 (diagonal is about root two)
  localparam logic [COST_W-1:0] STRAIGHT_RESET = 16'd256;
  localparam logic [COST_W-1:0] DIAG_RESET     = 16'd362;
  localparam logic [COST_W-1:0] WEIGHT_RESET   = 16'd256;

  // metric selection codes
  typedef enum logic [METRIC_W-1:0] {
    METRIC_DIAGONAL  = 3'd0,
    METRIC_MANHATTAN = 3'd1,
    METRIC_EUCLIDEAN = 3'd2,
    METRIC_CHEBYSHEV = 3'd3
  } metric_t;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [COORD_W-1:0]  goal_row;
    logic [COORD_W-1:0]  goal_col;
    logic [METRIC_W-1:0] metric_kind;
    logic [COST_W-1:0]   straight_cost;
    logic [COST_W-1:0]   diag_cost;
    logic [COST_W-1:0]   weight;
  } cfg_t;

  // bits of the square root result, integer part plus fraction
  function automatic int root_width(input int cw, input int fb);
    return cw + 1 + fb;
  endfunction

  // bits of the fixed point distance before weighting
  function automatic int dist_width(input int cw, input int fb);
    int diag_w;
    int shift_w;
    diag_w  = COST_W + cw + 1;
    shift_w = cw + 1 + fb;
    return (diag_w > shift_w) ? diag_w : shift_w;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/gdh_in_if.sv
// cell transaction channel: valid, ready and the cell coordinates
`default_nettype none

interface gdh_in_if;
  logic                         valid;
  logic                         ready;
  logic [gdh_pkg::COORD_W-1:0]  cell_row;
  logic [gdh_pkg::COORD_W-1:0]  cell_col;

  modport source (output valid, output cell_row, output cell_col, input ready);
  modport sink   (input valid, input cell_row, input cell_col, output ready);
endinterface

`default_nettype wire

FILE: hdl/gdh_out_if.sv
// estimate transaction channel: valid, ready and the weighted estimate
`default_nettype none

interface gdh_out_if;
  logic                       valid;
  logic                       ready;
  logic [gdh_pkg::EST_W-1:0]  estimate;

  modport source (output valid, output estimate, input ready);
  modport sink   (input valid, input estimate, output ready);
endinterface

`default_nettype wire

FILE: hdl/grid_distance_heuristic_top.sv
// top level of the weighted grid distance heuristic
`default_nettype none

// Weighted grid distance heuristic. Each transaction on in_ch carries a cell
// (cell_row, cell_col); one transaction on out_ch returns its estimate to the
// goal cell held in the registers, in unsigned Q24.8, saturating. The metric
// is diagonal, Manhattan, Euclidean (root rounded down) or Chebyshev; other
// codes and a zero weight give zero. The block takes one cell per clock, unless
// the output register holds a waiting result, and returns results in order.
// COORD_BITS is capped at 10. There are four front stages, one root stage per
// result bit of the square root, then weight multiply and output register. The
// whole pipeline advances on one enable, held back only while a result waits
// in the output register. The user must write registers only while no cell
// is in flight; the block itself does not enforce this.

module grid_distance_heuristic_top #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [gdh_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [gdh_pkg::CFG_DATA_W-1:0]    pwdata,
  output      logic [gdh_pkg::CFG_DATA_W-1:0]    prdata,
  output      logic                              pready,
  gdh_in_if.sink                                 in_ch,
  gdh_out_if.source                              out_ch
);

  localparam int CW = (COORD_BITS < gdh_pkg::COORD_W) ? COORD_BITS : gdh_pkg::COORD_W;
  localparam int RB = gdh_pkg::root_width(CW, FRAC_BITS);
  localparam int DW = gdh_pkg::dist_width(CW, FRAC_BITS);
  localparam int SW = 2 * CW + 1;

  gdh_pkg::cfg_t  cfg;
  logic           en;
  logic           fr_valid;
  logic [SW-1:0]  fr_sq_sum;
  logic [DW-1:0]  fr_dist;
  logic           fr_euc;
  logic           sq_valid;
  logic [RB-1:0]  sq_root;
  logic [DW:0]    sq_side;
  logic           bk_valid;

  // whole pipeline moves unless a result is held in the output register
  assign en          = !bk_valid || out_ch.ready;
  assign in_ch.ready = en;
  assign out_ch.valid = bk_valid;

  gdh_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gdh_front #(
    .CW        (CW),
    .FRAC_BITS (FRAC_BITS),
    .DW        (DW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .cell_row  (in_ch.cell_row),
    .cell_col  (in_ch.cell_col),
    .cfg       (cfg),
    .out_valid (fr_valid),
    .sq_sum    (fr_sq_sum),
    .dist_val  (fr_dist),
    .euc       (fr_euc)
  );

  // other metrics ride alongside the root as side data
  gdh_sqrt #(
    .SW        (SW),
    .RB        (RB),
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (DW + 1)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .in_s      (fr_sq_sum),
    .in_side   ({fr_euc, fr_dist}),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  gdh_back #(
    .RB        (RB),
    .DW        (DW),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .root      (sq_root),
    .dist_val  (sq_side[DW-1:0]),
    .euc       (sq_side[DW]),
    .weight    (cfg.weight),
    .out_valid (bk_valid),
    .estimate  (out_ch.estimate)
  );

endmodule

`default_nettype wire

FILE: hdl/gdh_cfg.sv
// configuration register bank behind the apb-style port
`default_nettype none

module gdh_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [gdh_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [gdh_pkg::CFG_DATA_W-1:0]    pwdata,
  output      logic [gdh_pkg::CFG_DATA_W-1:0]    prdata,
  output      logic                              pready,
  output      gdh_pkg::cfg_t                     cfg
);

  logic [gdh_pkg::COORD_W-1:0]  goal_row_r;
  logic [gdh_pkg::COORD_W-1:0]  goal_col_r;
  logic [gdh_pkg::METRIC_W-1:0] metric_kind_r;
  logic [gdh_pkg::COST_W-1:0]   straight_cost_r;
  logic [gdh_pkg::COST_W-1:0]   diag_cost_r;
  logic [gdh_pkg::COST_W-1:0]   weight_r;
  logic [gdh_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  // word-aligned register decode, no wait states
  assign reg_idx = paddr[gdh_pkg::CFG_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_row_r      <= '0;
      goal_col_r      <= '0;
      metric_kind_r   <= gdh_pkg::METRIC_DIAGONAL;
      straight_cost_r <= gdh_pkg::STRAIGHT_RESET;
      diag_cost_r     <= gdh_pkg::DIAG_RESET;
      weight_r        <= gdh_pkg::WEIGHT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        gdh_pkg::REG_GOAL_ROW:      goal_row_r      <= pwdata[gdh_pkg::COORD_W-1:0];
        gdh_pkg::REG_GOAL_COL:      goal_col_r      <= pwdata[gdh_pkg::COORD_W-1:0];
        gdh_pkg::REG_METRIC_KIND:   metric_kind_r   <= pwdata[gdh_pkg::METRIC_W-1:0];
        gdh_pkg::REG_STRAIGHT_COST: straight_cost_r <= pwdata[gdh_pkg::COST_W-1:0];
        gdh_pkg::REG_DIAG_COST:     diag_cost_r     <= pwdata[gdh_pkg::COST_W-1:0];
        gdh_pkg::REG_WEIGHT:        weight_r        <= pwdata[gdh_pkg::COST_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      gdh_pkg::REG_GOAL_ROW:      prdata = gdh_pkg::CFG_DATA_W'(goal_row_r);
      gdh_pkg::REG_GOAL_COL:      prdata = gdh_pkg::CFG_DATA_W'(goal_col_r);
      gdh_pkg::REG_METRIC_KIND:   prdata = gdh_pkg::CFG_DATA_W'(metric_kind_r);
      gdh_pkg::REG_STRAIGHT_COST: prdata = gdh_pkg::CFG_DATA_W'(straight_cost_r);
      gdh_pkg::REG_DIAG_COST:     prdata = gdh_pkg::CFG_DATA_W'(diag_cost_r);
      gdh_pkg::REG_WEIGHT:        prdata = gdh_pkg::CFG_DATA_W'(weight_r);
      default:                    prdata = '0;
    endcase
  end

  assign cfg.goal_row      = goal_row_r;
  assign cfg.goal_col      = goal_col_r;
  assign cfg.metric_kind   = metric_kind_r;
  assign cfg.straight_cost = straight_cost_r;
  assign cfg.diag_cost     = diag_cost_r;
  assign cfg.weight        = weight_r;

endmodule

`default_nettype wire

FILE: hdl/gdh_front.sv
// front pipeline: offsets, squares, cost products and metric selection
`default_nettype none

module gdh_front #(
  parameter int CW        = 10,
  parameter int FRAC_BITS = 8,
  parameter int DW        = 27
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [gdh_pkg::COORD_W-1:0]   cell_row,
  input  wire logic [gdh_pkg::COORD_W-1:0]   cell_col,
  input  wire gdh_pkg::cfg_t                 cfg,
  output      logic                          out_valid,
  output      logic [2*CW:0]                 sq_sum,
  output      logic [DW-1:0]                 dist_val,
  output      logic                          euc
);

  localparam int PW = gdh_pkg::COST_W + CW;
  localparam int SW = 2 * CW + 1;

  logic [CW-1:0]   cr;
  logic [CW-1:0]   cc;
  logic [CW-1:0]   gr;
  logic [CW-1:0]   gc;

  logic            v1_r, v2_r, v3_r, v4_r;
  logic [CW-1:0]   di_r, dj_r;
  logic [CW-1:0]   lo_r, hi_r;
  logic [2*CW-1:0] sqi_r, sqj_r;
  logic [CW:0]     sum_r;
  logic [PW-1:0]   ps_r, pd_r;
  logic [SW-1:0]   s3_r, s4_r;
  logic [CW:0]     man_r;
  logic [CW-1:0]   hi3_r;
  logic [DW-1:0]   dist_r, dist_nxt;
  logic            euc_r, euc_nxt;

  // only the low coordinate bits take part
  assign cr = cell_row[CW-1:0];
  assign cc = cell_col[CW-1:0];
  assign gr = cfg.goal_row[CW-1:0];
  assign gc = cfg.goal_col[CW-1:0];

  // valid bits move with the shared enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // stage one: absolute offsets to the goal
  always_ff @(posedge clk) begin
    if (en) begin
      di_r <= (cr >= gr) ? cr - gr : gr - cr;
      dj_r <= (cc >= gc) ? cc - gc : gc - cc;
    end
  end

  // stage two: ordering, squares and plain sum
  always_ff @(posedge clk) begin
    if (en) begin
      lo_r  <= (di_r < dj_r) ? di_r : dj_r;
      hi_r  <= (di_r < dj_r) ? dj_r : di_r;
      sqi_r <= (2*CW)'(di_r) * (2*CW)'(di_r);
      sqj_r <= (2*CW)'(dj_r) * (2*CW)'(dj_r);
      sum_r <= (CW+1)'(di_r) + (CW+1)'(dj_r);
    end
  end

  // stage three: cost products and sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      ps_r  <= PW'(cfg.straight_cost) * PW'(hi_r - lo_r);
      pd_r  <= PW'(cfg.diag_cost) * PW'(lo_r);
      s3_r  <= SW'(sqi_r) + SW'(sqj_r);
      man_r <= sum_r;
      hi3_r <= hi_r;
    end
  end

  // metric choice, the euclidean root is filled in after the root pipeline
  always_comb begin
    euc_nxt = 1'b0;
    case (gdh_pkg::metric_t'(cfg.metric_kind))
      gdh_pkg::METRIC_DIAGONAL:  dist_nxt = DW'(ps_r) + DW'(pd_r);
      gdh_pkg::METRIC_MANHATTAN: dist_nxt = DW'(man_r) << FRAC_BITS;
      gdh_pkg::METRIC_EUCLIDEAN: begin
        dist_nxt = '0;
        euc_nxt  = 1'b1;
      end
      gdh_pkg::METRIC_CHEBYSHEV: dist_nxt = DW'(hi3_r) << FRAC_BITS;
      default:                   dist_nxt = '0;
    endcase
  end

  // stage four: selected distance
  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= dist_nxt;
      euc_r  <= euc_nxt;
      s4_r   <= s3_r;
    end
  end

  assign out_valid = v4_r;
  assign sq_sum    = s4_r;
  assign dist_val  = dist_r;
  assign euc       = euc_r;

endmodule

`default_nettype wire

FILE: hdl/gdh_sqrt.sv
// pipelined digit-by-digit square root, one root bit per stage, with side data
`default_nettype none

module gdh_sqrt #(
  parameter int SW        = 21,
  parameter int RB        = 19,
  parameter int FRAC_BITS = 8,
  parameter int SIDE_W    = 28
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [SW-1:0]     in_s,
  input  wire logic [SIDE_W-1:0] in_side,
  output      logic              out_valid,
  output      logic [RB-1:0]     out_root,
  output      logic [SIDE_W-1:0] out_side
);

  // radicand is the input scaled by four to the power of the fraction bits
  localparam int XW = 2 * RB;
  localparam int RW = RB + 2;

  logic              v_r    [RB];
  logic [RW-1:0]     rem_r  [RB];
  logic [RB-1:0]     root_r [RB];
  logic [XW-1:0]     x_r    [RB];
  logic [SIDE_W-1:0] side_r [RB];

  for (genvar i = 0; i < RB; i++) begin : g_stage
    logic              v_in;
    logic [RW-1:0]     rem_in;
    logic [RB-1:0]     root_in;
    logic [XW-1:0]     x_in;
    logic [SIDE_W-1:0] side_in;
    logic [RW-1:0]     rem_sh;
    logic [RW-1:0]     trial;
    logic [RW-1:0]     rem_nxt;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = XW'(in_s) << (2 * FRAC_BITS);
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign x_in    = x_r[i-1];
      assign side_in = side_r[i-1];
    end

    // bring down the next pair of radicand bits and try a one digit
    assign rem_sh  = {rem_in[RW-3:0], x_in[XW-1 -: 2]};
    assign trial   = {root_in, 2'b01};
    assign ge      = (rem_sh >= trial);
    assign rem_nxt = ge ? rem_sh - trial : rem_sh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        root_r[i] <= {root_in[RB-2:0], ge};
        x_r[i]    <= x_in << 2;
        side_r[i] <= side_in;
      end
    end
  end

  assign out_valid = v_r[RB-1];
  assign out_root  = root_r[RB-1];
  assign out_side  = side_r[RB-1];

endmodule

`default_nettype wire

FILE: hdl/gdh_back.sv
// back pipeline: weight multiply, scaling, saturation and output register
`default_nettype none

module gdh_back #(
  parameter int RB        = 19,
  parameter int DW        = 27,
  parameter int FRAC_BITS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic [RB-1:0]                root,
  input  wire logic [DW-1:0]                dist_val,
  input  wire logic                         euc,
  input  wire logic [gdh_pkg::COST_W-1:0]   weight,
  output      logic                         out_valid,
  output      logic [gdh_pkg::EST_W-1:0]    estimate
);

  localparam int PW   = DW + gdh_pkg::COST_W;
  localparam int SH_W = PW - FRAC_BITS;

  logic                        v1_r;
  logic                        out_valid_r;
  logic [PW-1:0]               prod_r;
  logic [DW-1:0]               dist_sel;
  logic [SH_W-1:0]             scaled;
  logic [gdh_pkg::EST_W-1:0]   est_nxt;
  logic [gdh_pkg::EST_W-1:0]   estimate_r;

  assign dist_sel = euc ? DW'(root) : dist_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      out_valid_r <= v1_r;
    end
  end

  // weight product, a zero weight or zero distance gives zero
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PW'(dist_sel) * PW'(weight);
    end
  end

  assign scaled = prod_r[PW-1:FRAC_BITS];

  // clamp to the largest Q24.8 value where the product can exceed it
  if (SH_W > gdh_pkg::EST_W) begin : g_sat
    assign est_nxt = (|scaled[SH_W-1:gdh_pkg::EST_W]) ? '1 : scaled[gdh_pkg::EST_W-1:0];
  end else begin : g_nosat
    assign est_nxt = gdh_pkg::EST_W'(scaled);
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      estimate_r <= est_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign estimate  = estimate_r;

endmodule

`default_nettype wire

FILE: dv/grid_distance_heuristic_top_test.sv
// testbench for grid_distance_heuristic_top: directed and random cells checked against a predictor
`timescale 1ns / 100ps

module grid_distance_heuristic_top_test;

  localparam int FRAC = 8;
  localparam logic [gdh_pkg::COORD_W-1:0] COORD_MAX = '1;
  localparam logic [gdh_pkg::REG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd6;
  localparam logic [gdh_pkg::REG_IDX_W-1:0] REG_UNUSED_LAST  = 3'd7;
  localparam logic [gdh_pkg::METRIC_W-1:0] METRIC_SPARE_FIRST = 3'd4;
  localparam logic [gdh_pkg::METRIC_W-1:0] METRIC_SPARE_LAST  = 3'd7;
  localparam int PHASES = 20;
  localparam int CELLS_PER_PHASE = 78;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [gdh_pkg::CFG_ADDR_W-1:0] paddr;
  logic [gdh_pkg::CFG_DATA_W-1:0] pwdata;
  logic [gdh_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  gdh_in_if  cell_ch ();
  gdh_out_if est_ch ();

  // registers as the predictor sees them
  gdh_pkg::cfg_t goal_cfg;
  logic [gdh_pkg::EST_W-1:0] pending_estimates[$];
  int estimate_errors = 0;
  // set for a long stretch with no idling on either side
  bit steady = 1'b0;

  grid_distance_heuristic_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (cell_ch),
    .out_ch  (est_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // weighted estimate of one cell against the current goal
  function automatic logic [gdh_pkg::EST_W-1:0] weighted_estimate(
      logic [gdh_pkg::COORD_W-1:0] row, logic [gdh_pkg::COORD_W-1:0] col);
    longint unsigned di, dj, lo, hi, sc, dc, wt, dist_fx, sq, cand, prod;
    di = (row >= goal_cfg.goal_row) ? row - goal_cfg.goal_row : goal_cfg.goal_row - row;
    dj = (col >= goal_cfg.goal_col) ? col - goal_cfg.goal_col : goal_cfg.goal_col - col;
    lo = (di < dj) ? di : dj;
    hi = (di < dj) ? dj : di;
    sc = goal_cfg.straight_cost;
    dc = goal_cfg.diag_cost;
    wt = goal_cfg.weight;
    dist_fx = 0;
    case (goal_cfg.metric_kind)
      gdh_pkg::METRIC_DIAGONAL: dist_fx = sc * (hi - lo) + dc * lo;
      gdh_pkg::METRIC_MANHATTAN: dist_fx = (di + dj) << FRAC;
      gdh_pkg::METRIC_EUCLIDEAN: begin
        // floor of the root of the sum scaled by the square of the fraction
        sq = (di * di + dj * dj) << (2 * FRAC);
        for (int b = 20; b >= 0; b--) begin
          cand = dist_fx | (64'd1 << b);
          if (cand * cand <= sq) dist_fx = cand;
        end
      end
      gdh_pkg::METRIC_CHEBYSHEV: dist_fx = hi << FRAC;
      default: dist_fx = 0;
    endcase
    prod = (dist_fx * wt) >> FRAC;
    if (prod > 64'hFFFF_FFFF) prod = 64'hFFFF_FFFF;
    return prod[gdh_pkg::EST_W-1:0];
  endfunction

  // one register write: setup then access, predictor updated alongside
  task automatic cfg_write(logic [gdh_pkg::REG_IDX_W-1:0] idx,
                           logic [gdh_pkg::CFG_DATA_W-1:0] wdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      gdh_pkg::REG_GOAL_ROW:      goal_cfg.goal_row = wdata[gdh_pkg::COORD_W-1:0];
      gdh_pkg::REG_GOAL_COL:      goal_cfg.goal_col = wdata[gdh_pkg::COORD_W-1:0];
      gdh_pkg::REG_METRIC_KIND:   goal_cfg.metric_kind = wdata[gdh_pkg::METRIC_W-1:0];
      gdh_pkg::REG_STRAIGHT_COST: goal_cfg.straight_cost = wdata[gdh_pkg::COST_W-1:0];
      gdh_pkg::REG_DIAG_COST:     goal_cfg.diag_cost = wdata[gdh_pkg::COST_W-1:0];
      gdh_pkg::REG_WEIGHT:        goal_cfg.weight = wdata[gdh_pkg::COST_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic cfg_release();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // send one cell transaction, with random idle cycles ahead of it
  task automatic push_cell(logic [gdh_pkg::COORD_W-1:0] row,
                           logic [gdh_pkg::COORD_W-1:0] col);
    while (!steady && $urandom_range(99) < 20) begin
      cell_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cell_ch.valid <= 1'b1;
    cell_ch.cell_row <= row;
    cell_ch.cell_col <= col;
    @(posedge clk);
    while (!cell_ch.ready) @(posedge clk);
    pending_estimates = {pending_estimates, weighted_estimate(row, col)};
    @(negedge clk);
  endtask

  // stop sending and wait until every estimate has come back
  task automatic quiesce();
    cell_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_estimates.size() != 0);
  endtask

  // random register value, extremes favoured
  function automatic logic [gdh_pkg::CFG_DATA_W-1:0] pick_value(int width);
    logic [gdh_pkg::CFG_DATA_W-1:0] v;
    int sel;
    v = $urandom();
    sel = $urandom_range(9);
    if (sel == 0) v = '0;
    else if (sel == 1) v = '1;
    // junk above the field width is dropped by the block
    if ($urandom_range(1) == 0) v = v & ((32'd1 << width) - 1);
    return v;
  endfunction

  // receiver stalls
  always @(negedge clk) begin
    est_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 20);
  end

  // compare each estimate transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && est_ch.valid && est_ch.ready) begin
      if (pending_estimates.size() == 0) begin
        $display("%0t: unexpected estimate, expected none, actual %h", $time,
                 est_ch.estimate);
        estimate_errors++;
      end else begin
        if (est_ch.estimate !== pending_estimates[0]) begin
          $display("%0t: estimate mismatch, expected %h, actual %h", $time,
                   pending_estimates[0], est_ch.estimate);
          estimate_errors++;
        end
        void'(pending_estimates.pop_front());
      end
    end
  end

  task automatic test_reset_defaults();
    quiesce();
    push_cell('0, '0);
    push_cell(COORD_MAX, COORD_MAX);
    push_cell(COORD_MAX, '0);
    push_cell(10'd3, 10'd7);
  endtask

  task automatic test_each_metric();
    gdh_pkg::metric_t metric_order [4];
    metric_order = '{gdh_pkg::METRIC_DIAGONAL, gdh_pkg::METRIC_MANHATTAN,
                     gdh_pkg::METRIC_EUCLIDEAN, gdh_pkg::METRIC_CHEBYSHEV};
    foreach (metric_order[k]) begin
      quiesce();
      cfg_write(gdh_pkg::REG_GOAL_ROW, 32'd512);
      cfg_write(gdh_pkg::REG_GOAL_COL, 32'd300);
      cfg_write(gdh_pkg::REG_METRIC_KIND, 32'(metric_order[k]));
      cfg_release();
      push_cell('0, COORD_MAX);
      push_cell(COORD_MAX, '0);
      push_cell(10'd515, 10'd304);
    end
  endtask

  task automatic test_unknown_metric();
    for (int m = METRIC_SPARE_FIRST; m <= METRIC_SPARE_LAST; m++) begin
      quiesce();
      cfg_write(gdh_pkg::REG_METRIC_KIND, 32'(m));
      cfg_release();
      push_cell(COORD_MAX, 10'd17);
    end
  endtask

  task automatic test_zero_weight();
    quiesce();
    cfg_write(gdh_pkg::REG_METRIC_KIND, 32'(gdh_pkg::METRIC_EUCLIDEAN));
    cfg_write(gdh_pkg::REG_WEIGHT, 32'd0);
    cfg_release();
    push_cell('0, '0);
    push_cell(COORD_MAX, COORD_MAX);
  endtask

  // largest costs and weight; goal written with junk in the upper bits
  task automatic test_saturation();
    quiesce();
    cfg_write(gdh_pkg::REG_GOAL_ROW, 32'hFFFF_FC00);
    cfg_write(gdh_pkg::REG_GOAL_COL, 32'hFFFF_FFFF);
    cfg_write(gdh_pkg::REG_METRIC_KIND, 32'(gdh_pkg::METRIC_DIAGONAL));
    cfg_write(gdh_pkg::REG_STRAIGHT_COST, 32'hFFFF_FFFF);
    cfg_write(gdh_pkg::REG_DIAG_COST, 32'h5A5A_FFFF);
    cfg_write(gdh_pkg::REG_WEIGHT, 32'hFFFF_FFFF);
    cfg_release();
    push_cell(COORD_MAX, '0);
    push_cell(10'd1, 10'd1022);
  endtask

  // writes past the last register must leave everything as it was
  task automatic test_unused_address();
    quiesce();
    cfg_write(REG_UNUSED_FIRST, 32'hFFFF_FFFF);
    cfg_write(REG_UNUSED_LAST, 32'h0000_0000);
    cfg_release();
    push_cell(10'd700, 10'd2);
  endtask

  task automatic test_random_cells();
    int r, c, g, h, mode;
    for (int p = 0; p < PHASES; p++) begin
      quiesce();
      steady = (p >= 5 && p <= 7);
      case (p)
        0: begin
          cfg_write(gdh_pkg::REG_GOAL_ROW, 32'd0);
          cfg_write(gdh_pkg::REG_GOAL_COL, 32'd0);
          cfg_write(gdh_pkg::REG_METRIC_KIND, 32'(gdh_pkg::METRIC_DIAGONAL));
          cfg_write(gdh_pkg::REG_STRAIGHT_COST, 32'd0);
          cfg_write(gdh_pkg::REG_DIAG_COST, 32'd0);
          cfg_write(gdh_pkg::REG_WEIGHT, 32'd1);
        end
        1: begin
          cfg_write(gdh_pkg::REG_GOAL_ROW, 32'(COORD_MAX));
          cfg_write(gdh_pkg::REG_GOAL_COL, 32'(COORD_MAX));
          cfg_write(gdh_pkg::REG_METRIC_KIND, 32'(gdh_pkg::METRIC_EUCLIDEAN));
          cfg_write(gdh_pkg::REG_STRAIGHT_COST, 32'hFFFF);
          cfg_write(gdh_pkg::REG_DIAG_COST, 32'hFFFF);
          cfg_write(gdh_pkg::REG_WEIGHT, 32'hFFFF);
        end
        default: begin
          cfg_write(gdh_pkg::REG_GOAL_ROW, pick_value(gdh_pkg::COORD_W));
          cfg_write(gdh_pkg::REG_GOAL_COL, pick_value(gdh_pkg::COORD_W));
          // known metrics mostly, the spare codes now and then
          cfg_write(gdh_pkg::REG_METRIC_KIND, ($urandom_range(9) < 8) ?
                    $urandom_range(gdh_pkg::METRIC_CHEBYSHEV, gdh_pkg::METRIC_DIAGONAL) :
                    $urandom_range(METRIC_SPARE_LAST, METRIC_SPARE_FIRST));
          cfg_write(gdh_pkg::REG_STRAIGHT_COST, pick_value(gdh_pkg::COST_W));
          cfg_write(gdh_pkg::REG_DIAG_COST, pick_value(gdh_pkg::COST_W));
          cfg_write(gdh_pkg::REG_WEIGHT,
                    ($urandom_range(15) == 0) ? 32'd0 : pick_value(gdh_pkg::COST_W));
        end
      endcase
      cfg_release();
      for (int n = 0; n < CELLS_PER_PHASE; n++) begin
        mode = $urandom_range(9);
        g = goal_cfg.goal_row;
        h = goal_cfg.goal_col;
        r = $urandom_range(1023);
        c = $urandom_range(1023);
        if (mode >= 6 && mode <= 7) begin
          // close to the goal
          r = g + int'($urandom_range(16)) - 8;
          c = h + int'($urandom_range(16)) - 8;
        end else if (mode == 8) begin
          r = $urandom_range(1) ? 1023 : 0;
          c = $urandom_range(1) ? 1023 : 0;
        end else if (mode == 9) begin
          // on the goal row or column
          if ($urandom_range(1)) r = g; else c = h;
        end
        if (r < 0) r = 0;
        if (r > 1023) r = 1023;
        if (c < 0) c = 0;
        if (c > 1023) c = 1023;
        push_cell(r[gdh_pkg::COORD_W-1:0], c[gdh_pkg::COORD_W-1:0]);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cell_ch.valid = 1'b0;
    cell_ch.cell_row = '0;
    cell_ch.cell_col = '0;
    est_ch.ready = 1'b0;
    goal_cfg.goal_row = '0;
    goal_cfg.goal_col = '0;
    goal_cfg.metric_kind = gdh_pkg::METRIC_DIAGONAL;
    goal_cfg.straight_cost = gdh_pkg::STRAIGHT_RESET;
    goal_cfg.diag_cost = gdh_pkg::DIAG_RESET;
    goal_cfg.weight = gdh_pkg::WEIGHT_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_each_metric();
    test_unknown_metric();
    test_zero_weight();
    test_saturation();
    test_unused_address();
    test_random_cells();

    quiesce();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (estimate_errors == 0 && pending_estimates.size() == 0) begin
      $display("grid_distance_heuristic_top_test passed");
    end else begin
      $display("grid_distance_heuristic_top_test failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("grid_distance_heuristic_top_test failed");
    $finish;
  end

endmodule
